@@ sv/rcmr_pkg.sv @@
// Package: item types, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package rcmr_pkg;

	localparam int COEF_BITS = 8;
	localparam int PIX_W     = 24;
	localparam int SUM_W     = 21;
	localparam int QUO_W     = 20;
	localparam int DIV_STEPS = QUO_W;
	localparam int CFG_W     = 24;
	localparam int IDX_W     = 3;
	localparam logic [9:0] MIN_START = 10'd766;
	localparam logic [QUO_W-1:0] COMP_MAX = QUO_W'(255);

	localparam logic [IDX_W-1:0] REG_IMAGE_SIZE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_KROW_TOP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_KROW_MID    = 3'd2;
	localparam logic [IDX_W-1:0] REG_KROW_BOTTOM = 3'd3;
	localparam logic [IDX_W-1:0] REG_KSCALE      = 3'd4;
	localparam logic [IDX_W-1:0] REG_FILTER_EN   = 3'd5;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       image_done;
	} out_item_t;

	typedef struct packed {
		logic       accept;
		logic       shift;
		logic       mac;
		logic [3:0] idx;
		logic       fix;
		logic       div_load;
		logic       div_step;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic has_res;
		logic interior;
	} dp_sts_t;

endpackage

@@ sv/rcmr_datapath.sv @@
// Datapath: line stores, window, position counters, MAC, divider and output register.
`timescale 1ns / 1ps
module rcmr_datapath import rcmr_pkg::*; #(
	parameter int MAX_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  in_item_t         in_data,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output out_item_t        out_data
);
	localparam int AW = $clog2(MAX_SIZE);
	localparam int CW = $clog2(MAX_SIZE + 2);

	logic [10:0]        image_size_q;
	logic [CFG_W-1:0]   krow_q [3];
	logic [7:0]         kscale_q;
	logic               filter_q;

	logic [CW-1:0]      p_col_q, p_row_q;
	logic [CW-1:0]      n_eff, q_col, q_row;
	logic               has_res, interior, done, pixel_ok;

	logic [PIX_W-1:0]   mem_up [MAX_SIZE];
	logic [PIX_W-1:0]   mem_lo [MAX_SIZE];
	logic [PIX_W-1:0]   rd_up_s1, rd_lo_s1, px_s1;
	logic [AW-1:0]      col_s1;
	logic               res_s1, int_s1, done_s1;

	logic [PIX_W-1:0]   win_q [9];
	logic signed [SUM_W-1:0] sum_q [3];
	logic [PIX_W-1:0]   lo_px_q, hi_px_q;
	logic [9:0]         lo_s_q, hi_s_q;
	logic [QUO_W-1:0]   quo_q [3];
	logic [7:0]         rem_q [3];
	logic               neg_q [3];
	logic [7:0]         divisor;

	logic signed [COEF_BITS-1:0] cw;
	logic [PIX_W-1:0]   wsel;
	logic [9:0]         s_int;

	// effective size and position decode
	always_comb begin
		if (image_size_q < 11'd3)
			n_eff = CW'(3);
		else if (int'(image_size_q) > MAX_SIZE)
			n_eff = CW'(MAX_SIZE);
		else
			n_eff = CW'(image_size_q);
		has_res = (p_row_q >= CW'(2)) || (p_row_q == CW'(1) && p_col_q != '0);
		if (p_col_q == '0) begin
			q_col = n_eff - CW'(1);
			q_row = p_row_q - CW'(2);
		end else begin
			q_col = p_col_q - CW'(1);
			q_row = p_row_q - CW'(1);
		end
		interior = q_row >= CW'(1) && q_row <= n_eff - CW'(2) &&
			q_col >= CW'(1) && q_col <= n_eff - CW'(2);
		done = q_row == n_eff - CW'(1) && q_col == n_eff - CW'(1);
		pixel_ok = in_data.op == OP_PIXEL && p_row_q < n_eff;
	end

	assign divisor = (kscale_q == 8'd0) ? 8'd1 : kscale_q;
	assign sts.has_res = res_s1;
	assign sts.interior = int_s1;

	// config registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= 11'd3;
			krow_q[0] <= '0;
			krow_q[1] <= '0;
			krow_q[2] <= '0;
			kscale_q <= 8'd1;
			filter_q <= 1'b0;
			p_col_q <= '0;
			p_row_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_SIZE: begin
						image_size_q <= cfg_data[10:0];
						p_col_q <= '0;
						p_row_q <= '0;
					end
					REG_KROW_TOP:    krow_q[0] <= cfg_data;
					REG_KROW_MID:    krow_q[1] <= cfg_data;
					REG_KROW_BOTTOM: krow_q[2] <= cfg_data;
					REG_KSCALE:      kscale_q <= cfg_data[7:0];
					REG_FILTER_EN:   filter_q <= cfg_data[0];
					default: ;
				endcase
			end else if (cmd.accept) begin
				if (has_res && done) begin
					p_col_q <= '0;
					p_row_q <= '0;
				end else if (p_col_q == n_eff - CW'(1)) begin
					p_col_q <= '0;
					p_row_q <= p_row_q + CW'(1);
				end else begin
					p_col_q <= p_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= 1'b0;
			int_s1 <= 1'b0;
			done_s1 <= 1'b0;
		end else if (cmd.accept) begin
			res_s1 <= has_res;
			int_s1 <= interior;
			done_s1 <= done;
		end
	end

	// line stores: read on accept, write back in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_up_s1 <= mem_up[p_col_q[AW-1:0]];
			rd_lo_s1 <= mem_lo[p_col_q[AW-1:0]];
			col_s1 <= p_col_q[AW-1:0];
			px_s1 <= pixel_ok ? {in_data.in_blue, in_data.in_green, in_data.in_red} : '0;
		end
		if (cmd.shift) begin
			mem_up[col_s1] <= rd_lo_s1;
			mem_lo[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_up_s1;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_lo_s1;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	// coefficient for window index
	always_comb begin
		unique case (cmd.idx)
			4'd0:    cw = krow_q[0][0*COEF_BITS +: COEF_BITS];
			4'd1:    cw = krow_q[0][1*COEF_BITS +: COEF_BITS];
			4'd2:    cw = krow_q[0][2*COEF_BITS +: COEF_BITS];
			4'd3:    cw = krow_q[1][0*COEF_BITS +: COEF_BITS];
			4'd4:    cw = krow_q[1][1*COEF_BITS +: COEF_BITS];
			4'd5:    cw = krow_q[1][2*COEF_BITS +: COEF_BITS];
			4'd6:    cw = krow_q[2][0*COEF_BITS +: COEF_BITS];
			4'd7:    cw = krow_q[2][1*COEF_BITS +: COEF_BITS];
			4'd8:    cw = krow_q[2][2*COEF_BITS +: COEF_BITS];
			default: cw = '0;
		endcase
		wsel = (cmd.idx < 4'd9) ? win_q[cmd.idx] : '0;
		s_int = 10'(wsel[7:0]) + 10'(wsel[15:8]) + 10'(wsel[23:16]);
	end

	// accumulate, reject, divide
	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			for (int k = 0; k < 3; k++) begin
				if (cmd.idx == 4'd0)
					sum_q[k] <= SUM_W'($signed({1'b0, wsel[8*k +: 8]}) * cw);
				else
					sum_q[k] <= sum_q[k] + SUM_W'($signed({1'b0, wsel[8*k +: 8]}) * cw);
			end
			if (cmd.idx == 4'd0 || s_int <= lo_s_q) begin
				lo_s_q <= s_int;
				lo_px_q <= wsel;
			end
			if (cmd.idx == 4'd0 || s_int > hi_s_q) begin
				hi_s_q <= s_int;
				hi_px_q <= wsel;
			end
		end
		if (cmd.fix && filter_q) begin
			for (int k = 0; k < 3; k++)
				sum_q[k] <= sum_q[k] - $signed(SUM_W'(lo_px_q[8*k +: 8]))
					- $signed(SUM_W'(hi_px_q[8*k +: 8]));
		end
		if (cmd.div_load) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= sum_q[k][SUM_W-1];
				quo_q[k] <= sum_q[k][QUO_W-1:0];
				rem_q[k] <= '0;
			end
		end
		if (cmd.div_step) begin
			for (int k = 0; k < 3; k++) begin
				if ({rem_q[k], quo_q[k][QUO_W-1]} >= {1'b0, divisor}) begin
					rem_q[k] <= 8'({rem_q[k], quo_q[k][QUO_W-1]} - {1'b0, divisor});
					quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= {rem_q[k][6:0], quo_q[k][QUO_W-1]};
					quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data.image_done <= done_s1;
			if (int_s1) begin
				out_data.out_red   <= neg_q[0] ? 8'd0 : (quo_q[0] > COMP_MAX ? 8'd255 : quo_q[0][7:0]);
				out_data.out_green <= neg_q[1] ? 8'd0 : (quo_q[1] > COMP_MAX ? 8'd255 : quo_q[1][7:0]);
				out_data.out_blue  <= neg_q[2] ? 8'd0 : (quo_q[2] > COMP_MAX ? 8'd255 : quo_q[2][7:0]);
			end else begin
				out_data.out_red   <= win_q[4][7:0];
				out_data.out_green <= win_q[4][15:8];
				out_data.out_blue  <= win_q[4][23:16];
			end
		end
	end

endmodule

@@ sv/rcmr_ctrl.sv @@
// Controller: sequences one item through read, MAC, reject, divide and output.
`timescale 1ns / 1ps
module rcmr_ctrl import rcmr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MAC, S_FIX, S_DIV, S_OUT
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.idx = cnt_q[3:0];
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_RD:   cmd.shift = 1'b1;
			S_MAC:  cmd.mac = 1'b1;
			S_FIX: begin
				cmd.fix = 1'b1;
			end
			S_DIV: begin
				cmd.div_load = cnt_q == 5'd0;
				cmd.div_step = cnt_q != 5'd0;
			end
			S_OUT:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RD;
				S_RD: begin
					cnt_q <= '0;
					if (!sts.has_res)
						state_q <= S_IDLE;
					else if (sts.interior)
						state_q <= S_MAC;
					else
						state_q <= S_OUT;
				end
				S_MAC: begin
					if (cnt_q == 5'd8) begin
						cnt_q <= '0;
						state_q <= S_FIX;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_FIX: state_q <= S_DIV;
				S_DIV: begin
					// load first, then one quotient bit per cycle
					if (cnt_q == 5'(DIV_STEPS)) begin
						cnt_q <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/rgb_conv3x3_minmax_reject_top.sv @@
// Top level: 3x3 RGB convolution with min/max intensity rejection.
// Per item: read; a border result goes straight to output, an interior result
// runs through the 9-step shared MAC, a reject step and the 20-step bit-serial divider.
// An item without a result goes back to idle after the read.
// A finished result waits in the output register while the next item is taken.
// Reset clears control state, counters and window and sets config registers to defaults.
`timescale 1ns / 1ps
module rgb_conv3x3_minmax_reject_top import rcmr_pkg::*; #(
	parameter int MAX_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	rcmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcmr_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ sv/rcmr_checker.sv @@
// Checker on the top-level ports, bound to the top level.
`timescale 1ns / 1ps
module rcmr_checker import rcmr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	// an accepted item holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output item changed");

	// a result appears only out of an item in work
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output item without item in work");

endmodule

bind rgb_conv3x3_minmax_reject_top rcmr_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ test/rgb_conv3x3_minmax_reject_checker.sv @@
// Checker: watches both channels, predicts each output pixel and compares it.
`timescale 1ns / 1ps
module rgb_conv3x3_minmax_reject_checker import rcmr_pkg::*; #(
	parameter int MAX_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_data,
	output int               fail_count,
	output int               pending,
	output int               pixels_seen,
	output int               interior_seen
);
	logic [PIX_W-1:0] line_up[MAX_SIZE];
	logic [PIX_W-1:0] line_lo[MAX_SIZE];
	logic [PIX_W-1:0] win[9];
	int unsigned pos;
	logic [10:0] size_reg;
	logic [CFG_W-1:0] krow[3];
	logic [7:0] scale_reg;
	logic filt_reg;
	out_item_t expected_pixels[$];

	function automatic int size_eff();
		if (size_reg < 3) return 3;
		if (size_reg > MAX_SIZE) return MAX_SIZE;
		return size_reg;
	endfunction

	function automatic logic [PIX_W-1:0] filter_window();
		longint sum[3];
		longint dv, v, s, lo, hi;
		int lo_i, hi_i;
		logic [PIX_W-1:0] res;
		logic signed [7:0] w;
		sum = '{0, 0, 0};
		dv = (scale_reg == 0) ? 1 : scale_reg;
		res = '0;
		for (int i = 0; i < 9; i++) begin
			w = krow[i / 3][(i % 3) * 8 +: 8];
			for (int k = 0; k < 3; k++)
				sum[k] += longint'(win[i][8 * k +: 8]) * longint'(w);
		end
		if (filt_reg) begin
			lo = 766;
			hi = -1;
			lo_i = 0;
			hi_i = 0;
			for (int i = 0; i < 9; i++) begin
				s = win[i][7:0] + win[i][15:8] + win[i][23:16];
				if (s <= lo) begin
					lo = s;
					lo_i = i;
				end
				if (s > hi) begin
					hi = s;
					hi_i = i;
				end
			end
			for (int k = 0; k < 3; k++)
				sum[k] -= longint'(win[lo_i][8 * k +: 8]) + longint'(win[hi_i][8 * k +: 8]);
		end
		for (int k = 0; k < 3; k++) begin
			v = sum[k] / dv;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			res[8 * k +: 8] = v[7:0];
		end
		return res;
	endfunction

	task automatic advance_pixel(input in_item_t it);
		int n, p, col, q, rr, cc;
		logic [PIX_W-1:0] px, up, lo, res;
		out_item_t e;
		n = size_eff();
		p = pos;
		col = p % n;
		px = '0;
		if (it.op == OP_PIXEL && p < n * n) px = {it.in_blue, it.in_green, it.in_red};
		up = line_up[col];
		lo = line_lo[col];
		line_up[col] = lo;
		line_lo[col] = px;
		win[0] = win[1]; win[1] = win[2]; win[2] = up;
		win[3] = win[4]; win[4] = win[5]; win[5] = lo;
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		pos = (p + 1) & 21'h1FFFFF;
		if (p < n + 1) return;
		q = p - n - 1;
		rr = q / n;
		cc = q % n;
		if (rr >= 1 && rr + 2 <= n && cc >= 1 && cc + 2 <= n) begin
			res = filter_window();
			interior_seen++;
		end else
			res = win[4];
		e.out_red = res[7:0];
		e.out_green = res[15:8];
		e.out_blue = res[23:16];
		e.image_done = (q + 1 == n * n);
		if (q + 1 >= n * n) pos = 0;
		expected_pixels.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos = 0;
			size_reg = 3;
			krow = '{0, 0, 0};
			scale_reg = 1;
			filt_reg = 0;
			for (int i = 0; i < 9; i++) win[i] = '0;
			expected_pixels.delete();
			fail_count = 0;
			pending = 0;
			pixels_seen = 0;
			interior_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR %0t: unexpected output %h", $realtime, out_data);
				end else begin
					out_item_t e;
					e = expected_pixels.pop_front();
					if (out_data !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR %0t: exp r%h g%h b%h d%b got r%h g%h b%h d%b",
								$realtime, e.out_red, e.out_green, e.out_blue,
								e.image_done, out_data.out_red, out_data.out_green,
								out_data.out_blue, out_data.image_done);
					end
				end
			end
			if (in_valid && !in_stall) advance_pixel(in_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_SIZE: begin
						size_reg = cfg_data[10:0];
						pos = 0;
					end
					REG_KROW_TOP: krow[0] = cfg_data;
					REG_KROW_MID: krow[1] = cfg_data;
					REG_KROW_BOTTOM: krow[2] = cfg_data;
					REG_KSCALE: scale_reg = cfg_data[7:0];
					REG_FILTER_EN: filt_reg = cfg_data[0];
					default: ;
				endcase
			end
			pending = expected_pixels.size();
		end
	end

	final begin
		if (expected_pixels.size() != 0)
			$display("ERROR: %0d expected output pixels never arrived", expected_pixels.size());
	end
endmodule

@@ test/rgb_conv3x3_minmax_reject_top_test.sv @@
// Testbench top: drives images and register settings, gives the verdict.
`timescale 1ns / 1ps
module rgb_conv3x3_minmax_reject_top_test;
	import rcmr_pkg::*;

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	in_item_t in_data;
	out_item_t out_data;
	int fail_count, pending, pixels_seen, interior_seen;
	int items_sent, burst_left;
	int stall_mode;

	rgb_conv3x3_minmax_reject_top uut (.*);
	rgb_conv3x3_minmax_reject_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stall pattern: phases of none, light, heavy stalling
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic send_item(input logic op, input logic [23:0] rgb);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= {op, rgb[7:0], rgb[15:8], rgb[23:16]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one full image plus drain; kind 0 random, 1 extremes, 2 equal pixels
	task automatic send_image(input int n, input int kind);
		logic [23:0] rgb;
		for (int i = 0; i < n * n + n + 1; i++) begin
			case (kind)
				1: rgb = (i % 2) ? 24'hFFFFFF : 24'h000000;
				2: rgb = 24'h404040;
				default: rgb = 24'($urandom);
			endcase
			if (i >= n * n)
				send_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, 24'($urandom));
			else
				send_item(($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_PIXEL, rgb);
		end
	endtask

	task automatic random_kernel();
		write_reg(REG_KROW_TOP, CFG_W'($urandom));
		write_reg(REG_KROW_MID, CFG_W'($urandom));
		write_reg(REG_KROW_BOTTOM, CFG_W'($urandom));
		write_reg(REG_KSCALE, CFG_W'($urandom_range(0, 255)));
		write_reg(REG_FILTER_EN, CFG_W'($urandom));
	endtask

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		items_sent = 0;
		burst_left = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reset defaults, then identity-like kernels and extremes
		send_image(3, 1);
		wait_idle();
		write_reg(REG_KROW_MID, 24'h000100);
		send_image(3, 0);
		wait_idle();
		write_reg(REG_IMAGE_SIZE, CFG_W'(4));
		write_reg(REG_KROW_TOP, 24'h7F7F7F);
		write_reg(REG_KROW_MID, 24'h7F7F7F);
		write_reg(REG_KROW_BOTTOM, 24'h7F7F7F);
		write_reg(REG_KSCALE, CFG_W'(1));
		write_reg(REG_FILTER_EN, CFG_W'(1));
		send_image(4, 1);
		wait_idle();
		write_reg(REG_KROW_TOP, 24'h808080);
		write_reg(REG_KROW_MID, 24'h808080);
		write_reg(REG_KROW_BOTTOM, 24'h808080);
		write_reg(REG_KSCALE, CFG_W'(255));
		send_image(4, 2);
		wait_idle();
		write_reg(REG_KSCALE, CFG_W'(0));
		write_reg(REG_IMAGE_SIZE, CFG_W'(1));
		send_image(3, 0);
		wait_idle();
		while (items_sent < 1700) begin
			random_kernel();
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(3, 7);
			write_reg(REG_IMAGE_SIZE, CFG_W'(n));
			send_image(n, 0);
			wait_idle();
		end
		// large size settings: write then abandon before any result
		write_reg(REG_IMAGE_SIZE, CFG_W'(2047));
		send_item(OP_PIXEL, 24'($urandom));
		repeat (60) @(negedge clk);
		write_reg(REG_IMAGE_SIZE, CFG_W'(1024));
		send_item(OP_PIXEL, 24'($urandom));
		repeat (60) @(negedge clk);
		write_reg(REG_IMAGE_SIZE, CFG_W'(3));
		send_image(3, 0);
		wait_idle();
		$display("Sent %0d items; %0d output pixels checked, %0d of them filtered interior.",
			items_sent, pixels_seen, interior_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
